// ===== src/vtf_pkg.sv =====
// Shared types, constants and codes for the video tile fetch core.
package vtf_pkg;

    localparam int MEM_DEPTH       = 16384;
    localparam int MEM_AW          = $clog2(MEM_DEPTH);
    localparam int DEF_LINE_LAST   = 340;
    localparam int DEF_FRAME_LINES = 263;
    localparam int VBLANK_LINE     = 242;
    localparam int TILE_COUNT      = 960;
    localparam int CMD_Q_DEPTH     = 2;

    typedef enum logic [2:0] {
        A_ADDR   = 3'd0,
        A_DATA   = 3'd1,
        A_STATUS = 3'd2,
        A_TICK   = 3'd3,
        A_RENDER = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        K_RESULT = 2'd0,
        K_WRITE  = 2'd1,
        K_RENDER = 2'd2
    } t_kind;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [9:0] tile_index;
    } t_in;

    typedef struct packed {
        logic [7:0] status_byte;
        logic       nmi_pulse;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] color_index;
        logic       last_item;
    } t_out;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        status;
        logic              nmi;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
        logic [9:0]        tile;
        logic [1:0]        nt;
        logic              pat;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NAME,
        S_ATTR,
        S_LO,
        S_HI,
        S_PAL,
        S_EMIT
    } t_bstate;

endpackage

// ===== src/vtf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/vtf_front.sv =====
// Front end: port registers, frame timing, status and command build.
module vtf_front import vtf_pkg::*; #(
    parameter int LINE_LAST_DOT = DEF_LINE_LAST,
    parameter int FRAME_LINES   = DEF_FRAME_LINES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_accept,
    input  t_in        i_in,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);
    logic [7:0]  r_ctl;
    logic [15:0] r_ptr, n_ptr;
    logic        r_hbp, n_hbp;
    logic        r_clr, n_clr;
    logic [7:0]  r_status, n_status;
    logic [8:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        nmi;
    logic [13:0] a14;
    logic [MEM_AW-1:0] waddr;

    // 0x3000..0x3EFF folds onto the nametables, 0x3F20 and up onto the palette
    always_comb begin
        a14 = r_ptr[13:0];
        if (a14 >= 14'h3000 && a14 <= 14'h3EFF) begin
            waddr = a14 - 14'h1000;
        end else if (a14 >= 14'h3F20) begin
            waddr = {9'h1F8, a14[4:0]};
        end else begin
            waddr = a14;
        end
    end

    always_comb begin
        n_ptr    = r_ptr;
        n_hbp    = r_hbp;
        n_clr    = r_clr;
        n_status = r_status;
        n_dot    = r_dot;
        n_line   = r_line;
        nmi      = 1'b0;
        case (t_action'(i_in.action))
            A_ADDR: begin
                if (!r_hbp) begin
                    n_ptr = {i_in.data_byte, 8'h00};
                    n_hbp = 1'b1;
                end else begin
                    n_ptr = r_ptr + {8'h00, i_in.data_byte};
                    n_hbp = 1'b0;
                end
            end
            A_DATA: begin
                n_ptr = r_ptr + (r_ctl[2] ? 16'd32 : 16'd1);
            end
            A_STATUS: begin
                n_clr = 1'b1;
            end
            A_TICK: begin
                if (r_clr) begin
                    n_status = n_status & 8'h7F;
                    n_clr    = 1'b0;
                end
                if (r_line == 9'd0 && r_dot == 9'd1) begin
                    n_status = n_status & 8'h1F;
                end else if (r_line == 9'(VBLANK_LINE) && r_dot == 9'd1) begin
                    n_status = n_status | 8'h80;
                    nmi      = r_ctl[7];
                end
                if (r_dot < 9'(LINE_LAST_DOT)) begin
                    n_dot = r_dot + 9'd1;
                end else begin
                    n_dot  = 9'd0;
                    n_line = (r_line == 9'(FRAME_LINES - 1)) ? 9'd0 : r_line + 9'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd.status = n_status;
        o_cmd.nmi    = nmi;
        o_cmd.addr   = waddr;
        o_cmd.data   = i_in.data_byte;
        o_cmd.tile   = i_in.tile_index;
        o_cmd.nt     = r_ctl[1:0];
        o_cmd.pat    = r_ctl[3];
        case (t_action'(i_in.action))
            A_DATA:   o_cmd.kind = K_WRITE;
            A_RENDER: o_cmd.kind = K_RENDER;
            default:  o_cmd.kind = K_RESULT;
        endcase
    end

    // an out-of-range render is taken but yields nothing
    assign o_cmd_push = i_accept &&
        !(i_in.action == A_RENDER && i_in.tile_index >= 10'(TILE_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '0;
            r_ptr    <= '0;
            r_hbp    <= 1'b0;
            r_clr    <= 1'b0;
            r_status <= '0;
            r_dot    <= '0;
            r_line   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ctl <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_ptr    <= n_ptr;
                r_hbp    <= n_hbp;
                r_clr    <= n_clr;
                r_status <= n_status;
                r_dot    <= n_dot;
                r_line   <= n_line;
            end
        end
    end
endmodule

// ===== src/vtf_cmd_q.sv =====
// Small command queue between front and back end.
module vtf_cmd_q import vtf_pkg::*; #(
    parameter int DEPTH = CMD_Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_q [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end
endmodule

// ===== src/vtf_back.sv =====
// Back end: memory writes, tile fetch sequencer and result register.
module vtf_back import vtf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    output logic              o_we,
    output logic [MEM_AW-1:0] o_waddr,
    output logic [7:0]        o_wdata,
    output logic              o_re,
    output logic [MEM_AW-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    input  logic              i_pop,
    output logic              o_empty,
    output t_out              o_out
);
    t_bstate    r_state, n_state;
    t_cmd       r_cmd;
    logic [7:0] r_name, r_lo, r_hi;
    logic [1:0] r_ph;
    logic [2:0] r_row, r_px;
    t_out       r_out;
    logic       r_out_vld;
    logic       out_free, start, load_simple, emit;
    logic [4:0] tx, ty;
    logic [2:0] rd_row, b;
    logic       hi_sel;
    logic [1:0] sq, pl;

    assign out_free = !r_out_vld || i_pop;
    assign tx = r_cmd.tile[4:0];
    assign ty = r_cmd.tile[9:5];
    assign b  = 3'd7 - r_px;
    assign pl = {r_hi[b], r_lo[b]};
    assign sq = {ty[1], tx[1]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_q_empty && i_q_cmd.kind == K_RENDER) n_state = S_NAME;
            S_NAME: n_state = S_ATTR;
            S_ATTR: n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_PAL;
            S_PAL:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    if (r_px != 3'd7) n_state = S_PAL;
                    else if (r_row == 3'd7) n_state = S_IDLE;
                    else n_state = S_LO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        start       = 1'b0;
        load_simple = 1'b0;
        emit        = 1'b0;
        o_re        = 1'b0;
        o_raddr     = '0;
        hi_sel      = 1'b0;
        rd_row      = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_cmd.kind == K_RENDER) begin
                        start   = 1'b1;
                        o_re    = 1'b1;
                        o_raddr = {2'b10, i_q_cmd.nt, i_q_cmd.tile};
                    end else if (out_free) begin
                        load_simple = 1'b1;
                    end
                end
            end
            S_NAME: begin
                o_re    = 1'b1;
                o_raddr = {2'b10, r_cmd.nt, 4'hF, ty[4:2], tx[4:2]};
            end
            S_ATTR, S_LO: begin
                hi_sel  = (r_state == S_LO);
                o_re    = 1'b1;
                o_raddr = {1'b0, r_cmd.pat, r_name, hi_sel, rd_row};
            end
            S_PAL: begin
                o_re    = 1'b1;
                o_raddr = {6'h3F, 4'h0, r_ph, pl};
            end
            S_EMIT: begin
                emit = out_free;
                if (out_free && r_px == 3'd7 && r_row != 3'd7) begin
                    rd_row  = r_row + 3'd1;
                    o_re    = 1'b1;
                    o_raddr = {1'b0, r_cmd.pat, r_name, 1'b0, rd_row};
                end
            end
            S_HI: begin
            end
            default: begin
            end
        endcase
    end

    assign o_q_pop = start || load_simple;
    assign o_we    = load_simple && i_q_cmd.kind == K_WRITE;
    assign o_waddr = i_q_cmd.addr;
    assign o_wdata = i_q_cmd.data;
    assign o_empty = !r_out_vld;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd <= i_q_cmd;
            r_row <= '0;
            r_px  <= '0;
        end
        if (r_state == S_NAME) r_name <= i_rdata;
        if (r_state == S_ATTR) r_ph <= 2'(i_rdata >> {sq, 1'b0});
        if (r_state == S_LO)   r_lo <= i_rdata;
        if (r_state == S_HI)   r_hi <= i_rdata;
        if (emit) begin
            r_px <= r_px + 3'd1;
            if (r_px == 3'd7) r_row <= r_row + 3'd1;
        end
        if (load_simple) begin
            r_out <= '{status_byte: i_q_cmd.status, nmi_pulse: i_q_cmd.nmi,
                       pixel_x: 8'd0, pixel_y: 8'd0, color_index: 8'd0,
                       last_item: 1'b1};
        end else if (emit) begin
            r_out <= '{status_byte: r_cmd.status, nmi_pulse: 1'b0,
                       pixel_x: {tx, r_px}, pixel_y: {ty, r_row},
                       color_index: i_rdata,
                       last_item: (r_px == 3'd7 && r_row == 3'd7)};
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_simple || emit) r_out_vld <= 1'b1;
            else if (i_pop) r_out_vld <= 1'b0;
        end
    end
endmodule

// ===== src/video_ppu_vram_port_timing_tile_fetch_core.sv =====
// Top level of the video tile fetch core: front end, command queue, back end, VRAM.
// A port access, status read or tick passes through the command queue, then the
// result register. Throughput: one such item per cycle while results are popped;
// a tile render holds the back end for name and attribute reads, then per row the
// pattern reads and per pixel a palette read and an emit, paced by registered VRAM reads.
// Reset (synchronous, active low) clears pointer, timing, status, control and queues;
// video memory is not cleared and holds garbage until written.
module video_ppu_vram_port_timing_tile_fetch_core import vtf_pkg::*; #(
    parameter int LINE_LAST_DOT = DEF_LINE_LAST,
    parameter int FRAME_LINES   = DEF_FRAME_LINES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  t_in        i_in,
    output logic       empty,
    input  logic       pop,
    output t_out       o_out
);
    logic              accept, cmd_push, q_pop, q_empty;
    t_cmd              cmd_in, cmd_head;
    logic              we, re;
    logic [MEM_AW-1:0] waddr, raddr;
    logic [7:0]        wdata, rdata;

    assign accept = push && !full;

    // front end updates architectural state as each item is taken
    vtf_front #(
        .LINE_LAST_DOT (LINE_LAST_DOT),
        .FRAME_LINES   (FRAME_LINES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    vtf_cmd_q #(
        .DEPTH (CMD_Q_DEPTH)
    ) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_cmd   (cmd_head)
    );

    // back end performs writes in order with renders, so reads see prior writes
    vtf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (cmd_head),
        .o_q_pop   (q_pop),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_re      (re),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

    vtf_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );
endmodule
